### src/acic_pkg.sv
// ----------------------------------------------------------------------------
// acic_pkg
// Shared types, constants and coinage tables of the custom I/O credit unit.
// ----------------------------------------------------------------------------
package acic_pkg;

  localparam int CREDIT_W        = 7;
  localparam int MAX_CREDITS_DEF = 99;
  localparam int SHOW_LIMIT      = 99;

  // access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // chip selects
  localparam logic CHIP_ONE = 1'b0;
  localparam logic CHIP_TWO = 1'b1;

  // chip modes held in the mode register
  localparam logic [7:0] MODE_CREDIT = 8'd4;
  localparam logic [7:0] MODE_TEST   = 8'd8;
  localparam logic [7:0] MODE_SWITCH = 8'd9;

  // register offsets
  localparam logic [3:0] OFF_TENS    = 4'd0;
  localparam logic [3:0] OFF_UNITS   = 4'd1;
  localparam logic [3:0] OFF_PB_HI   = 4'd1;
  localparam logic [3:0] OFF_ZERO    = 4'd2;
  localparam logic [3:0] OFF_PA_LO   = 4'd3;
  localparam logic [3:0] OFF_JOY     = 4'd4;
  localparam logic [3:0] OFF_PA_HI   = 4'd4;
  localparam logic [3:0] OFF_FIRE    = 4'd5;
  localparam logic [3:0] OFF_FILL_LO = 4'd6;
  localparam logic [3:0] OFF_FILL_HI = 4'd7;
  localparam logic [3:0] OFF_MODE    = 4'd8;
  localparam logic [3:0] OFF_TEST_LO = 4'd9;

  localparam logic [7:0] NIBBLE_MASK = 8'h0f;
  localparam logic [7:0] FILL_VALUE  = 8'h0f;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;  // capture the accepted request
    logic exec;     // decode, update state, stage the result
    logic finish;   // load the result register
  } acic_cmd_t;

  // coinage tables, indexed by port 1 bits 2:0
  function automatic logic [2:0] coin_num(input logic [2:0] sel);
    logic [2:0] n;
    case (sel)
      3'd0:    n = 3'd1;
      3'd1:    n = 3'd2;
      3'd2:    n = 3'd3;
      3'd3:    n = 3'd6;
      3'd4:    n = 3'd7;
      3'd5:    n = 3'd1;
      3'd6:    n = 3'd3;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] coin_den(input logic [2:0] sel);
    logic [1:0] d;
    case (sel)
      3'd5:    d = 2'd2;
      3'd6:    d = 2'd2;
      3'd7:    d = 2'd3;
      default: d = 2'd1;
    endcase
    return d;
  endfunction

endpackage

### src/arcade_custom_io_credit_unit.sv
// An accepted request is captured, then executed, then finished into the
//   result register by the controller's execute and finish steps; a new
//   request is taken during the finish step.
// A stalled result holds its register and blocks the next finish step.
// Reset (synchronous) clears both chips' registers, the credit count and the
//   coin, start and fire latches, and drops out_valid.
// ----------------------------------------------------------------------------
// arcade_custom_io_credit_unit
// Two custom I/O chips with coin credit counting, behind a request handshake.
// ----------------------------------------------------------------------------
module arcade_custom_io_credit_unit
  import acic_pkg::*;
#(
  parameter int MAX_CREDITS = MAX_CREDITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic       chip_select,
  input  logic [3:0] reg_offset,
  input  logic [7:0] write_data,
  input  logic [7:0] switch_port_a,
  input  logic [7:0] switch_port_b,
  input  logic [7:0] switch_port_c,
  input  logic [7:0] switch_port_d,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data
);

  acic_cmd_t cmd;

  acic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  acic_dp #(
    .MAX_CREDITS (MAX_CREDITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .command       (command),
    .chip_select   (chip_select),
    .reg_offset    (reg_offset),
    .write_data    (write_data),
    .switch_port_a (switch_port_a),
    .switch_port_b (switch_port_b),
    .switch_port_c (switch_port_c),
    .switch_port_d (switch_port_d),
    .read_data     (read_data)
  );

endmodule

### src/acic_ctrl.sv
// ----------------------------------------------------------------------------
// acic_ctrl
// Request sequencer: accept, execute, finish into the result register.
// ----------------------------------------------------------------------------
module acic_ctrl
  import acic_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output acic_cmd_t cmd
);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_FIN} state_t;

  state_t state;
  logic   fin_go;

  // result register free this cycle
  assign fin_go   = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) || (state == ST_FIN && fin_go);

  assign cmd.load_in = in_valid && in_ready;
  assign cmd.exec    = (state == ST_EXEC);
  assign cmd.finish  = (state == ST_FIN) && fin_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          // overlap the next request with the finish step
          if (fin_go) state <= in_valid ? ST_EXEC : ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### src/acic_dp.sv
// ----------------------------------------------------------------------------
// acic_dp
// Datapath: chip registers, credit counter, latches and read formatting.
// ----------------------------------------------------------------------------
module acic_dp
  import acic_pkg::*;
#(
  parameter int MAX_CREDITS = MAX_CREDITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  acic_cmd_t  cmd,
  input  logic       command,
  input  logic       chip_select,
  input  logic [3:0] reg_offset,
  input  logic [7:0] write_data,
  input  logic [7:0] switch_port_a,
  input  logic [7:0] switch_port_b,
  input  logic [7:0] switch_port_c,
  input  logic [7:0] switch_port_d,
  output logic [7:0] read_data
);

  // captured request
  logic       a_cmd;
  logic       a_chip;
  logic [3:0] a_off;
  logic [7:0] a_data;
  logic [7:0] a_pa;
  logic [7:0] a_pb;
  logic [7:0] a_pc;
  logic [7:0] a_pd;

  // architectural state
  logic [7:0]          regs_one [16];
  logic [7:0]          regs_two [16];
  logic [CREDIT_W-1:0] credit;
  logic                coin_latch;
  logic                start_latch;
  logic                fire_latch;

  // staged result
  logic       b_show;
  logic       b_units;
  logic [1:0] b_den;
  logic [9:0] b_prod;
  logic [7:0] b_direct;

  // execute-step signals
  logic [7:0]          mode_one;
  logic [7:0]          mode_two;
  logic [1:0]          den;
  logic [2:0]          num;
  logic                coin;
  logic                s1;
  logic                s2;
  logic [CREDIT_W-1:0] den_one;
  logic [CREDIT_W-1:0] den_two;
  logic [CREDIT_W-1:0] c_coin;
  logic [CREDIT_W-1:0] c_s1;
  logic [CREDIT_W-1:0] c_s2;
  logic                hit1;
  logic                hit2;
  logic                start_next;
  logic                upd_credit;
  logic                clr_credit;
  logic                upd_fire;
  logic                show_next;
  logic [7:0]          direct_next;

  // finish-step signals
  logic [19:0] third;
  logic [9:0]  quot;
  logic [6:0]  shown;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  units;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_cmd  <= command;
      a_chip <= chip_select;
      a_off  <= reg_offset;
      a_data <= write_data;
      a_pa   <= switch_port_a;
      a_pb   <= switch_port_b;
      a_pc   <= switch_port_c;
      a_pd   <= switch_port_d;
    end
  end

  assign mode_one = regs_one[OFF_MODE];
  assign mode_two = regs_two[OFF_MODE];
  assign den      = coin_den(a_pb[2:0]);
  assign num      = coin_num(a_pb[2:0]);
  assign coin     = a_pd[0];
  assign s1       = a_pd[4];
  assign s2       = a_pd[5];
  assign den_one  = {{(CREDIT_W-2){1'b0}}, den};
  assign den_two  = {{(CREDIT_W-3){1'b0}}, den, 1'b0};

  // coin edge, then single start, then double start
  always_comb begin
    if (coin && !coin_latch && credit < CREDIT_W'(MAX_CREDITS)) begin
      c_coin = credit + CREDIT_W'(1);
    end else begin
      c_coin = credit;
    end
    hit1 = s1 && !start_latch && (c_coin >= den_one);
    c_s1 = hit1 ? c_coin - den_one : c_coin;
    hit2 = s2 && !start_latch && !hit1 && (c_s1 >= den_two);
    c_s2 = hit2 ? c_s1 - den_two : c_s1;
    start_next = (s1 || s2) && (start_latch || hit1 || hit2);
  end

  always_comb begin
    upd_credit  = 1'b0;
    clr_credit  = 1'b0;
    upd_fire    = 1'b0;
    show_next   = 1'b0;
    direct_next = 8'd0;
    if (a_cmd == CMD_READ) begin
      if (a_chip == CHIP_ONE) begin
        if (mode_one == MODE_CREDIT) begin
          case (a_off)
            OFF_TENS, OFF_UNITS: begin
              upd_credit = 1'b1;
              show_next  = 1'b1;
            end
            OFF_JOY: begin
              direct_next = a_pc & NIBBLE_MASK;
            end
            OFF_FIRE: begin
              upd_fire    = 1'b1;
              direct_next = {4'd0, a_pc[7:5], a_pc[4] | (a_pc[5] & !fire_latch)};
            end
            OFF_FILL_LO, OFF_FILL_HI: begin
              direct_next = FILL_VALUE;
            end
            default: begin
              direct_next = regs_one[a_off];
            end
          endcase
        end else begin
          clr_credit  = (mode_one == MODE_TEST);
          direct_next = (clr_credit && a_off >= OFF_TEST_LO) ? 8'd0 : regs_one[a_off];
        end
      end else begin
        if (mode_two == MODE_SWITCH) begin
          case (a_off)
            OFF_TENS:  direct_next = a_pb & NIBBLE_MASK;
            OFF_PB_HI: direct_next = {4'd0, a_pb[7:4]};
            OFF_PA_LO: direct_next = a_pa & NIBBLE_MASK;
            OFF_PA_HI: direct_next = {4'd0, a_pa[7:4]};
            OFF_ZERO, OFF_FIRE, OFF_FILL_LO, OFF_FILL_HI: direct_next = 8'd0;
            default:   direct_next = regs_two[a_off];
          endcase
        end else begin
          clr_credit  = (mode_two == MODE_TEST);
          direct_next = (clr_credit && a_off >= OFF_TEST_LO) ? 8'd0 : regs_two[a_off];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        regs_one[i] <= 8'd0;
        regs_two[i] <= 8'd0;
      end
      credit      <= '0;
      coin_latch  <= 1'b0;
      start_latch <= 1'b0;
      fire_latch  <= 1'b0;
    end else if (cmd.exec) begin
      if (a_cmd == CMD_WRITE) begin
        if (a_chip == CHIP_TWO) begin
          regs_two[a_off] <= a_data;
        end else begin
          regs_one[a_off] <= a_data;
        end
      end
      if (upd_credit) begin
        credit      <= c_s2;
        coin_latch  <= coin;
        start_latch <= start_next;
      end
      if (clr_credit) credit <= '0;
      if (upd_fire) fire_latch <= a_pc[5];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      b_show   <= show_next;
      b_units  <= a_off[0];
      b_den    <= den;
      b_prod   <= {3'd0, c_s2} * {7'd0, num};
      b_direct <= direct_next;
    end
  end

  // divide by the coinage denominator; thirds by reciprocal (exact below 694)
  assign third = {10'd0, b_prod} * 20'd683;

  always_comb begin
    case (b_den)
      2'd2:    quot = {1'b0, b_prod[9:1]};
      2'd3:    quot = {1'b0, third[19:11]};
      default: quot = b_prod;
    endcase
    shown = (quot > 10'(SHOW_LIMIT)) ? 7'(SHOW_LIMIT) : quot[6:0];
    tens  = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (shown >= 7'(k * 10)) tens = 4'(k);
    end
    // ten times tens as eight times plus two times
    tens_x10 = {tens, 3'd0} + {2'd0, tens, 1'b0};
    units    = shown - tens_x10;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (b_show) begin
        read_data <= b_units ? {1'b0, units} : {4'd0, tens};
      end else begin
        read_data <= b_direct;
      end
    end
  end

endmodule

### src/acic_chk.sv
// ----------------------------------------------------------------------------
// acic_chk
// Port-level checker for the credit unit, bound to the top level.
// ----------------------------------------------------------------------------
module acic_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data
);

  logic [1:0] pending;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // count requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("result changed while stalled");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("request accepted in back-to-back cycles");

  a_source: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without an outstanding request");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two requests outstanding");

endmodule

bind arcade_custom_io_credit_unit acic_chk u_chk (.*);
